[src/astt_pkg.sv]
// ----------------------------------------------------------------------------
// astt_pkg
// Shared types and constants of the address space target table: op and
// status codes, the sweep record that walks the cell chain and the write
// command broadcast to the cells.
// ----------------------------------------------------------------------------
package astt_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int SLOTS_MAX  = 64;
    // slot indexes are carried at the width of the largest table
    localparam int SLOT_IDX_W = $clog2(SLOTS_MAX);

    localparam int PID_W   = 32;
    localparam int BASE_W  = 64;
    localparam int FLAG_W  = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [BASE_W-1:0] BASE_MASK = 64'h000F_FFFF_FFFF_F000;

    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_EN  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDE_MASK = 1'b1;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_UPDATE = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DISABLED  = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO_BASE = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        WR_NEW,
        WR_REFRESH,
        WR_FLAGS,
        WR_CLEAR
    } wr_kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINISH
    } state_t;

    // lookup key held by the top level while a request sweeps the chain
    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [BASE_W-1:0] base;
    } key_t;

    // record handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic                  vld;
        logic                  pid_hit;
        logic [SLOT_IDX_W-1:0] pid_slot;
        logic                  free_hit;
        logic [SLOT_IDX_W-1:0] free_slot;
        logic                  base_hit;
        logic [SLOT_IDX_W-1:0] base_slot;
        logic [PID_W-1:0]      hit_pid;
        logic [BASE_W-1:0]     hit_base;
        logic [FLAG_W-1:0]     hit_flags;
        logic                  hide_all;
        logic                  hide_excl;
    } sweep_t;

    typedef struct packed {
        logic                  en;
        wr_kind_t              kind;
        logic [SLOT_IDX_W-1:0] slot;
        logic [PID_W-1:0]      pid;
        logic [BASE_W-1:0]     base;
        logic [FLAG_W-1:0]     flags;
    } wr_cmd_t;

endpackage

[src/astt_cell.sv]
// ----------------------------------------------------------------------------
// astt_cell
// One table entry. Compares the held key against its entry as the sweep
// record passes, folds its answer into the record and takes writes aimed at
// its own slot.
// ----------------------------------------------------------------------------
module astt_cell #(
    parameter int IDX = 0
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  astt_pkg::key_t                      key,
    input  logic [astt_pkg::FLAG_W-1:0]         hide_mask,
    input  astt_pkg::wr_cmd_t                   wr,
    input  astt_pkg::sweep_t                    sw_in,
    output astt_pkg::sweep_t                    sw_out
);

    localparam logic [astt_pkg::SLOT_IDX_W-1:0] MY_SLOT = astt_pkg::SLOT_IDX_W'(IDX);

    logic                          valid_reg;
    logic [astt_pkg::PID_W-1:0]    pid_reg;
    logic [astt_pkg::BASE_W-1:0]   base_reg;
    logic [astt_pkg::FLAG_W-1:0]   flags_reg;

    astt_pkg::sweep_t sw_reg, sw_next;

    logic pid_match, first_pid, free_first, base_first, hide_here, wr_here;

    assign pid_match  = valid_reg && (pid_reg == key.pid);
    assign first_pid  = pid_match && !sw_in.pid_hit;
    assign free_first = !valid_reg && !sw_in.free_hit;
    assign base_first = valid_reg && !sw_in.base_hit
                        && (((base_reg ^ key.base) & astt_pkg::BASE_MASK) == '0);
    assign hide_here  = valid_reg && ((flags_reg & hide_mask) != '0);
    assign wr_here    = wr.en && (wr.slot == MY_SLOT);

    always_comb begin
        sw_next           = sw_in;
        sw_next.pid_hit   = sw_in.pid_hit | pid_match;
        sw_next.free_hit  = sw_in.free_hit | !valid_reg;
        sw_next.base_hit  = sw_in.base_hit | base_first;
        sw_next.hide_all  = sw_in.hide_all | hide_here;
        // hide bits of every entry other than the one a refresh, flag update or remove touches
        sw_next.hide_excl = sw_in.hide_excl | (hide_here && !first_pid);
        if (first_pid) begin
            sw_next.pid_slot = MY_SLOT;
        end
        if (free_first) begin
            sw_next.free_slot = MY_SLOT;
        end
        if (base_first) begin
            sw_next.base_slot = MY_SLOT;
            sw_next.hit_pid   = pid_reg;
            sw_next.hit_base  = base_reg;
            sw_next.hit_flags = flags_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= '0;
        end else begin
            sw_reg <= sw_next;
        end
    end

    assign sw_out = sw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (wr_here) begin
            valid_reg <= (wr.kind == astt_pkg::WR_CLEAR) ? 1'b0 :
                         (wr.kind == astt_pkg::WR_NEW)   ? 1'b1 : valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_here) begin
            unique case (wr.kind)
                astt_pkg::WR_NEW: begin
                    pid_reg   <= wr.pid;
                    base_reg  <= wr.base;
                    flags_reg <= wr.flags;
                end
                astt_pkg::WR_REFRESH: begin
                    base_reg  <= wr.base;
                    flags_reg <= wr.flags;
                end
                astt_pkg::WR_FLAGS: begin
                    flags_reg <= wr.flags;
                end
                astt_pkg::WR_CLEAR: begin
                    pid_reg   <= '0;
                    base_reg  <= '0;
                    flags_reg <= '0;
                end
                default: begin
                    flags_reg <= flags_reg;
                end
            endcase
        end
    end

endmodule

[src/address_space_target_table_unit.sv]
// ----------------------------------------------------------------------------
// address_space_target_table_unit
// Small associative table of tracked address spaces, built as a chain of
// entry cells swept by each request.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (op, proc_id, table_base, flag_word) and
// each gives exactly one result on the m_ channel. Add, remove and update
// need tracking_enable; find works at any time. Registers are written through
// cfg_wr_en / cfg_wr_index / cfg_wr_data; the user must do so only while the
// table is idle, as the block itself does not enforce it.
// A request is latched, then its record walks the SLOTS cells, one cell per
// cycle, collecting the first id match, the first free slot, the first base
// match and the hide bits. When the record leaves the last cell it is held
// in tail_reg; the result is then decided and the chosen cell written once
// the output is free. s_tready comes back in the same cycle as m_tvalid, so
// a new request is taken only after the previous result has been issued.
// Reset clears every valid mark, the entry count and the registers
// (tracking_enable 0, hide_flag_mask 1). While the receiver stalls, the result
// holds and the finished request waits at the end of the chain, taking no new one.
// ----------------------------------------------------------------------------
module address_space_target_table_unit #(
    parameter int SLOTS = astt_pkg::SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [astt_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [astt_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op[1:0], proc_id[33:2], table_base[97:34], flag_word[129:98], zero fill
    input  logic [135:0]                      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[2:0], hit[3], slot[7:4], entry_id[39:8], entry_base[103:40],
    // entry_flags[135:104], active_count[140:136], any_hide[141], zero fill
    output logic [143:0]                      m_tdata
);

    localparam int CNT_W = $clog2(SLOTS + 1);

    astt_pkg::state_t state_reg, state_next;

    logic                              track_en_reg;
    logic [astt_pkg::FLAG_W-1:0]       hide_mask_reg;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic                              start_reg;

    astt_pkg::op_t                     op_reg;
    astt_pkg::key_t                    key_reg;
    logic [astt_pkg::FLAG_W-1:0]       flags_reg;
    astt_pkg::sweep_t                  tail_reg;

    logic                              m_tvalid_reg;
    logic [143:0]                      m_tdata_reg;

    astt_pkg::sweep_t                  chain [SLOTS+1];
    astt_pkg::wr_cmd_t                 wr;

    logic                              accept, out_free, commit, new_hide, hide_raw;
    astt_pkg::status_t                 res_status;
    logic                              res_hit;
    logic [astt_pkg::SLOT_IDX_W-1:0]   res_slot;
    logic [astt_pkg::PID_W-1:0]        res_pid;
    logic [astt_pkg::BASE_W-1:0]       res_base;
    logic [astt_pkg::FLAG_W-1:0]       res_flags;
    logic [CNT_W+4:0]                  cnt_wide;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == astt_pkg::S_IDLE);
    assign new_hide = (flags_reg & hide_mask_reg) != '0;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_en_reg  <= 1'b0;
            hide_mask_reg <= astt_pkg::FLAG_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                astt_pkg::CFG_TRACK_EN:  track_en_reg  <= cfg_wr_data[0];
                astt_pkg::CFG_HIDE_MASK: hide_mask_reg <= cfg_wr_data;
                default:                 track_en_reg  <= track_en_reg;
            endcase
        end
    end

    // request holding registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg       <= astt_pkg::op_t'(s_tdata[1:0]);
            key_reg.pid  <= s_tdata[33:2];
            key_reg.base <= s_tdata[97:34];
            flags_reg    <= s_tdata[129:98];
        end
        if (chain[SLOTS].vld) begin
            tail_reg <= chain[SLOTS];
        end
    end

    // cell chain
    always_comb begin
        chain[0]     = '0;
        chain[0].vld = start_reg;
    end

    for (genvar i = 0; i < SLOTS; i++) begin : g_cell
        astt_cell #(
            .IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key       (key_reg),
            .hide_mask (hide_mask_reg),
            .wr        (wr),
            .sw_in     (chain[i]),
            .sw_out    (chain[i+1])
        );
    end

    // state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= astt_pkg::S_IDLE;
            start_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= accept;
        end
    end

    always_comb begin
        state_next = state_reg;
        commit     = 1'b0;
        unique case (state_reg)
            astt_pkg::S_IDLE: begin
                if (accept) begin
                    state_next = astt_pkg::S_SWEEP;
                end
            end
            astt_pkg::S_SWEEP: begin
                if (chain[SLOTS].vld) begin
                    state_next = astt_pkg::S_FINISH;
                end
            end
            astt_pkg::S_FINISH: begin
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = astt_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = astt_pkg::S_IDLE;
            end
        endcase
    end

    // decision from the finished sweep
    always_comb begin
        res_status = astt_pkg::ST_OK;
        res_hit    = 1'b0;
        res_slot   = '0;
        res_pid    = '0;
        res_base   = '0;
        res_flags  = '0;
        cnt_next   = cnt_reg;
        hide_raw   = tail_reg.hide_all;
        wr         = '0;
        wr.pid     = key_reg.pid;
        wr.base    = key_reg.base;
        wr.flags   = flags_reg;
        if (op_reg == astt_pkg::OP_FIND) begin
            if (tail_reg.base_hit) begin
                res_hit   = 1'b1;
                res_slot  = tail_reg.base_slot;
                res_pid   = tail_reg.hit_pid;
                res_base  = tail_reg.hit_base;
                res_flags = tail_reg.hit_flags;
            end else begin
                res_status = astt_pkg::ST_NOT_FOUND;
            end
        end else if (!track_en_reg) begin
            res_status = astt_pkg::ST_DISABLED;
        end else if (op_reg == astt_pkg::OP_ADD) begin
            if (key_reg.base == '0) begin
                res_status = astt_pkg::ST_ZERO_BASE;
            end else if (tail_reg.pid_hit) begin
                wr.en    = commit;
                wr.kind  = astt_pkg::WR_REFRESH;
                wr.slot  = tail_reg.pid_slot;
                res_slot = tail_reg.pid_slot;
                hide_raw = tail_reg.hide_excl | new_hide;
            end else if (tail_reg.free_hit) begin
                wr.en    = commit;
                wr.kind  = astt_pkg::WR_NEW;
                wr.slot  = tail_reg.free_slot;
                res_slot = tail_reg.free_slot;
                cnt_next = cnt_reg + CNT_W'(1);
                hide_raw = tail_reg.hide_all | new_hide;
            end else begin
                res_status = astt_pkg::ST_FULL;
            end
        end else if (!tail_reg.pid_hit) begin
            res_status = astt_pkg::ST_NOT_FOUND;
        end else if (op_reg == astt_pkg::OP_REMOVE) begin
            wr.en    = commit;
            wr.kind  = astt_pkg::WR_CLEAR;
            wr.slot  = tail_reg.pid_slot;
            res_slot = tail_reg.pid_slot;
            cnt_next = cnt_reg - CNT_W'(1);
            hide_raw = tail_reg.hide_excl;
        end else begin
            wr.en    = commit;
            wr.kind  = astt_pkg::WR_FLAGS;
            wr.slot  = tail_reg.pid_slot;
            res_slot = tail_reg.pid_slot;
            hide_raw = tail_reg.hide_excl | new_hide;
        end
    end

    assign cnt_wide = {5'd0, cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (commit) begin
                cnt_reg      <= cnt_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_tdata_reg <= {2'b00, track_en_reg & hide_raw, cnt_wide[4:0], res_flags,
                            res_base, res_pid, res_slot[3:0], res_hit, res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/astt_checker.sv]
// ----------------------------------------------------------------------------
// astt_checker
// Port-level checks of the address space target table: request and result
// ordering, result hold under stall and the form of results.
// ----------------------------------------------------------------------------
module astt_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata
);

    // a result waiting for the receiver keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a request is being worked on in the cycle after it is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("table not busy right after a request");

    // a hit always reports ok
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[2:0] == astt_pkg::ST_OK)
        else $error("hit with error status");

    // entry contents are only shown on a hit
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> m_tdata[135:8] == '0)
        else $error("entry data on a result without hit");

endmodule

bind address_space_target_table_unit astt_checker u_astt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
